[hw/rtl/annexb_nal_boundary_scanner_unit_assert.svh]
// Assertion macros shared by the checker of the Annex B boundary scanner.
`ifndef ANNEXB_NAL_BOUNDARY_SCANNER_UNIT_ASSERT_SVH
`define ANNEXB_NAL_BOUNDARY_SCANNER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define ANBS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define ANBS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/anbs_pkg.sv]
// Shared types and constants of the Annex B NAL boundary scanner.
`timescale 1ns / 1ps
package anbs_pkg;

  localparam logic [15:0] HeaderSkipRst  = 16'd52;
  localparam logic [21:0] BufferBytesRst = 22'd1048628;
  localparam logic [9:0]  MaxUnitsRst    = 10'd512;
  localparam logic [23:0] RecentRst      = 24'hFFFFFF;
  localparam logic [7:0]  TypeMask       = 8'h1F;
  localparam logic [7:0]  StartByte      = 8'h01;

  // Record queue depth, a power of two.
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [1:0] {
    REG_HEADER_SKIP  = 2'd0,
    REG_BUFFER_BYTES = 2'd1,
    REG_MAX_UNITS    = 2'd2
  } cfg_reg_e;

  // Raw record from the scanner; the end is trimmed in the back part.
  typedef struct packed {
    logic [20:0] unit_start;
    logic [21:0] payload_start;
    logic [21:0] last_nonzero_end;
    logic [4:0]  unit_type;
    logic        unit_present;
    logic        is_final;
    logic [9:0]  unit_count;
  } rec_t;

  typedef struct packed {
    logic push;
    rec_t rec;
  } q_wr_t;

  typedef struct packed {
    logic valid;
    rec_t rec;
  } q_rd_t;

endpackage

[hw/rtl/anbs_if.sv]
// Channel interfaces of the Annex B NAL boundary scanner.
`timescale 1ns / 1ps
interface anbs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
  modport mon (input valid, input data_byte, input ready);
endinterface

interface anbs_out_if;
  logic        valid;
  logic        ready;
  logic [20:0] unit_start;
  logic [21:0] payload_start;
  logic [21:0] unit_end;
  logic [4:0]  unit_type;
  logic        unit_present;
  logic        is_final;
  logic [9:0]  unit_count;

  modport source (output valid, output unit_start, output payload_start, output unit_end,
                  output unit_type, output unit_present, output is_final,
                  output unit_count, input ready);
  modport sink (input valid, input unit_start, input payload_start, input unit_end,
                input unit_type, input unit_present, input is_final,
                input unit_count, output ready);
  modport mon (input valid, input unit_start, input payload_start, input unit_end,
               input unit_type, input unit_present, input is_final,
               input unit_count, input ready);
endinterface

interface anbs_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  addr;
  logic [21:0] wdata;

  modport source (output valid, output addr, output wdata, input ready);
  modport sink (input valid, input addr, input wdata, output ready);
  modport mon (input valid, input addr, input wdata, input ready);
endinterface

[hw/rtl/anbs_front.sv]
// Scanner front: config registers, start code detection, unit tracking.
`timescale 1ns / 1ps
module anbs_front #(
  parameter int unsigned ADDR_BITS = 21,
  parameter int unsigned MAX_UNITS = 512
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  anbs_cfg_if.sink             cfg_i,
  anbs_in_if.sink              in_i,
  input  logic                 full_i,
  output anbs_pkg::q_wr_t      wr_o
);

  // Positions never exceed 22 bits since buffer_bytes is 22 bits wide.
  localparam int unsigned PW = (ADDR_BITS < 22) ? ADDR_BITS : 22;
  localparam int unsigned UW = $clog2(MAX_UNITS + 1);
  localparam int unsigned LW = (UW > 10) ? UW : 10;
  localparam logic [22:0] Span = 23'(1) << PW;

  logic [15:0]   hdr_skip_q;
  logic [21:0]   buf_bytes_q;
  logic [9:0]    max_units_q;

  logic [PW-1:0] pos_q, pos_d;
  logic [23:0]   recent_q, recent_d;
  logic [PW-1:0] ustart_q, ustart_d;
  logic [PW-1:0] pay_q, pay_d;
  logic [PW:0]   lne_q, lne_d;
  logic [4:0]    type_q, type_d;
  logic          open_q, open_d;
  logic [UW-1:0] cnt_q, cnt_d;

  logic          accept;
  logic [7:0]    b;
  logic [22:0]   n_cap, n_eff;
  logic [23:0]   n24, p24, hs24, pay24;
  logic [LW-1:0] limit, cnt_ext;
  logic          room, ok4, ok3, found, last;
  logic [PW-1:0] code_at;
  logic [4:0]    type_cur;
  logic [22:0]   start_ext, pay_ext, lne_ext;
  logic [PW-1:0] rec_start, rec_pay;
  logic [PW:0]   rec_lne;
  logic [UW-1:0] rec_cnt;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = !full_i;
  assign accept      = in_i.valid && in_i.ready;
  assign b           = in_i.data_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_skip_q  <= anbs_pkg::HeaderSkipRst;
      buf_bytes_q <= anbs_pkg::BufferBytesRst;
      max_units_q <= anbs_pkg::MaxUnitsRst;
    end else if (cfg_i.valid) begin
      case (anbs_pkg::cfg_reg_e'(cfg_i.addr))
        anbs_pkg::REG_HEADER_SKIP:  hdr_skip_q  <= cfg_i.wdata[15:0];
        anbs_pkg::REG_BUFFER_BYTES: buf_bytes_q <= cfg_i.wdata;
        anbs_pkg::REG_MAX_UNITS:    max_units_q <= cfg_i.wdata[9:0];
        default: ;
      endcase
    end
  end

  // Effective length: capped at the position span, never below one.
  always_comb begin
    n_cap = ({1'b0, buf_bytes_q} > Span) ? Span : {1'b0, buf_bytes_q};
    n_eff = (n_cap == 23'd0) ? 23'd1 : n_cap;
  end

  assign n24     = {1'b0, n_eff};
  assign p24     = 24'(pos_q);
  assign hs24    = 24'(hdr_skip_q);
  assign pay24   = 24'(pay_q);
  assign cnt_ext = LW'(cnt_q);
  assign limit   = (LW'(max_units_q) < LW'(MAX_UNITS)) ? LW'(max_units_q) : LW'(MAX_UNITS);
  assign room    = cnt_ext < limit;
  assign last    = (p24 + 24'd1) >= n24;

  // Four-byte code begins at p-3, three-byte code at p-2.
  always_comb begin
    ok4 = (b == anbs_pkg::StartByte) && (p24 >= 24'd3) && (recent_q == 24'd0)
          && (p24 >= hs24 + 24'd3) && !(open_q && (p24 <= pay24 + 24'd3))
          && (p24 + 24'd2 < n24) && room;
    ok3 = (b == anbs_pkg::StartByte) && (p24 >= 24'd2) && (recent_q[15:0] == 16'd0)
          && (p24 >= hs24 + 24'd2) && !(open_q && (p24 <= pay24 + 24'd2))
          && (p24 + 24'd3 < n24) && room;
    found   = ok4 || ok3;
    code_at = ok4 ? (pos_q - PW'(3)) : (pos_q - PW'(2));
  end

  // The header byte lands at the payload offset.
  assign type_cur = (open_q && (pos_q == pay_q)) ? 5'(b & anbs_pkg::TypeMask) : type_q;

  always_comb begin
    ustart_d = found ? code_at : ustart_q;
    pay_d    = found ? (pos_q + PW'(1)) : pay_q;
    type_d   = found ? 5'd0 : type_cur;
    open_d   = open_q || found;
    cnt_d    = found ? (cnt_q + UW'(1)) : cnt_q;
    lne_d    = (b != 8'd0) ? ((PW+1)'(pos_q) + (PW+1)'(1)) : lne_q;
    recent_d = {recent_q[15:0], b};
    pos_d    = pos_q + PW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      recent_q <= anbs_pkg::RecentRst;
      ustart_q <= '0;
      pay_q    <= '0;
      lne_q    <= '0;
      type_q   <= '0;
      open_q   <= 1'b0;
      cnt_q    <= '0;
    end else if (accept) begin
      if (last) begin
        pos_q    <= '0;
        recent_q <= anbs_pkg::RecentRst;
        ustart_q <= '0;
        pay_q    <= '0;
        lne_q    <= '0;
        type_q   <= '0;
        open_q   <= 1'b0;
        cnt_q    <= '0;
      end else begin
        pos_q    <= pos_d;
        recent_q <= recent_d;
        ustart_q <= ustart_d;
        pay_q    <= pay_d;
        lne_q    <= lne_d;
        type_q   <= type_d;
        open_q   <= open_d;
        cnt_q    <= cnt_d;
      end
    end
  end

  // Final record wins over a closing record of the same byte.
  always_comb begin
    rec_start = last ? ustart_d : ustart_q;
    rec_pay   = last ? pay_d : pay_q;
    rec_lne   = last ? lne_d : lne_q;
    rec_cnt   = last ? cnt_d : cnt_q;
    start_ext = 23'(rec_start);
    pay_ext   = 23'(rec_pay);
    lne_ext   = 23'(rec_lne);
    wr_o.push                 = accept && (last || (found && open_q));
    wr_o.rec.unit_start       = start_ext[20:0];
    wr_o.rec.payload_start    = pay_ext[21:0];
    wr_o.rec.last_nonzero_end = lne_ext[21:0];
    wr_o.rec.unit_type        = last ? type_d : type_cur;
    wr_o.rec.unit_present     = last ? open_d : 1'b1;
    wr_o.rec.is_final         = last;
    wr_o.rec.unit_count       = 10'(rec_cnt);
  end

endmodule

[hw/rtl/anbs_queue.sv]
// Short record queue between scanner front and output back.
`timescale 1ns / 1ps
module anbs_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  anbs_pkg::q_wr_t wr_i,
  output logic            full_o,
  output anbs_pkg::q_rd_t rd_o,
  input  logic            pop_i
);

  localparam int unsigned PtrW = (anbs_pkg::QueueDepth > 1) ? $clog2(anbs_pkg::QueueDepth) : 1;

  anbs_pkg::rec_t mem_q [anbs_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]   cnt_q;
  logic            do_push, do_pop;

  assign full_o    = (cnt_q == (PtrW+1)'(anbs_pkg::QueueDepth));
  assign do_push   = wr_i.push && !full_o;
  assign do_pop    = pop_i && (cnt_q != '0);
  assign rd_o.valid = (cnt_q != '0);
  assign rd_o.rec   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wr_i.rec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + (PtrW+1)'(1);
        2'b01:   cnt_q <= cnt_q - (PtrW+1)'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

[hw/rtl/anbs_back.sv]
// Output back: trims unit end and holds the record for the sink.
`timescale 1ns / 1ps
module anbs_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  anbs_pkg::q_rd_t rd_i,
  output logic            pop_o,
  anbs_out_if.source      out_o
);

  logic        valid_q;
  logic [21:0] end_d;
  logic [20:0] start_q;
  logic [21:0] pay_q, end_q;
  logic [4:0]  type_q;
  logic        present_q, final_q;
  logic [9:0]  cnt_q;

  assign pop_o = rd_i.valid && (!valid_q || out_o.ready);

  // Trailing zeros never pull the end below the payload offset.
  always_comb begin
    if (!rd_i.rec.unit_present) begin
      end_d = '0;
    end else if (rd_i.rec.last_nonzero_end < rd_i.rec.payload_start) begin
      end_d = rd_i.rec.payload_start;
    end else begin
      end_d = rd_i.rec.last_nonzero_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      start_q   <= rd_i.rec.unit_start;
      pay_q     <= rd_i.rec.payload_start;
      end_q     <= end_d;
      type_q    <= rd_i.rec.unit_type;
      present_q <= rd_i.rec.unit_present;
      final_q   <= rd_i.rec.is_final;
      cnt_q     <= rd_i.rec.unit_count;
    end
  end

  assign out_o.valid         = valid_q;
  assign out_o.unit_start    = start_q;
  assign out_o.payload_start = pay_q;
  assign out_o.unit_end      = end_q;
  assign out_o.unit_type     = type_q;
  assign out_o.unit_present  = present_q;
  assign out_o.is_final      = final_q;
  assign out_o.unit_count    = cnt_q;

endmodule

[hw/rtl/annexb_nal_boundary_scanner_unit.sv]
// Top level of the Annex B NAL boundary scanner.
//
//   channel | dir | payload                                   | accepted when
//   --------+-----+-------------------------------------------+-------------------------
//   cfg_i   | in  | addr (register index), wdata              | cfg_i.valid & cfg_i.ready
//   in_i    | in  | data_byte                                 | in_i.valid & in_i.ready
//   out_o   | out | unit_start, payload_start, unit_end,      | out_o.valid & out_o.ready
//           |     | unit_type, unit_present, is_final, count  |
//
// One byte per clock, unless stalled; the front does all detection in that cycle.
// A record reaches out_o through the record queue and then the output register.
// Reset loads register defaults and clears scan state at once; there is no clearing pass.
// in_i.ready drops only while the two-entry record queue is full; out_o holds under stall.
// cfg_i is always ready; write it only while no transaction is in flight.
`timescale 1ns / 1ps
module annexb_nal_boundary_scanner_unit #(
  parameter int unsigned ADDR_BITS = 21,
  parameter int unsigned MAX_UNITS = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  anbs_cfg_if.sink    cfg_i,
  anbs_in_if.sink     in_i,
  anbs_out_if.source  out_o
);

  anbs_pkg::q_wr_t q_wr;
  anbs_pkg::q_rd_t q_rd;
  logic            q_full;
  logic            q_pop;

  // Front: classify each byte, track the open unit, push records.
  anbs_front #(
    .ADDR_BITS (ADDR_BITS),
    .MAX_UNITS (MAX_UNITS)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .in_i   (in_i),
    .full_i (q_full),
    .wr_o   (q_wr)
  );

  // Queue: decouple front and back so either may stall alone.
  anbs_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (q_wr),
    .full_o (q_full),
    .rd_o   (q_rd),
    .pop_i  (q_pop)
  );

  // Back: trim the unit end and present the record transaction.
  anbs_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rd_i   (q_rd),
    .pop_o  (q_pop),
    .out_o  (out_o)
  );

endmodule

[hw/rtl/anbs_checker.sv]
// Port-level checker of the Annex B NAL boundary scanner, with its bind.
`timescale 1ns / 1ps
`include "annexb_nal_boundary_scanner_unit_assert.svh"
module anbs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  anbs_cfg_if.sink   cfg_i,
  anbs_in_if.sink    in_i,
  anbs_out_if.source out_o
);

  logic unused_mon;
  assign unused_mon = cfg_i.valid ^ in_i.valid;

  `ANBS_ASSERT_NEXT(a_out_hold, out_o.valid && !out_o.ready, out_o.valid && $stable(out_o.unit_end) && $stable(out_o.unit_count), "record dropped or changed under stall")
  `ANBS_ASSERT_NOW(a_end_order, out_o.valid && out_o.unit_present, (out_o.unit_end >= out_o.payload_start) && (out_o.payload_start > 22'(out_o.unit_start)), "unit offsets out of order")
  `ANBS_ASSERT_NOW(a_empty_final, out_o.valid && !out_o.unit_present, out_o.is_final && (out_o.unit_count == 10'd0) && (out_o.unit_end == 22'd0) && (out_o.unit_type == 5'd0), "empty record not a clean final")
  `ANBS_ASSERT_NOW(a_count_set, out_o.valid && out_o.unit_present, out_o.unit_count != 10'd0, "unit record with zero ordinal")

endmodule

bind annexb_nal_boundary_scanner_unit anbs_checker u_anbs_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .cfg_i  (cfg_i),
  .in_i   (in_i),
  .out_o  (out_o)
);

[bench/tb_top.sv]
// Self-checking testbench for the Annex B NAL boundary scanner unit.
`timescale 1ns / 1ps
module tb_top;

  localparam int unsigned AddrBits  = 21;
  localparam int unsigned UnitCap   = 512;
  localparam int unsigned PosSpan   = 1 << AddrBits;
  localparam int unsigned RandBytes = 740;
  localparam int unsigned Settle    = 8;

  // One unit record as the scanner reports it on out_o.
  typedef struct packed {
    logic [20:0] unit_start;
    logic [21:0] payload_start;
    logic [21:0] unit_end;
    logic [4:0]  unit_type;
    logic        unit_present;
    logic        is_final;
    logic [9:0]  unit_count;
  } nal_rec_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  anbs_cfg_if cfg_bus ();
  anbs_in_if  byte_bus ();
  anbs_out_if rec_bus ();

  annexb_nal_boundary_scanner_unit #(
    .ADDR_BITS(AddrBits),
    .MAX_UNITS(UnitCap)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_bus),
    .in_i  (byte_bus),
    .out_o (rec_bus)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Bytes waiting to be offered, records the scanner still owes, staging for one buffer.
  logic [7:0] byte_backlog[$];
  nal_rec_t   unit_records_due[$];
  logic [7:0] stream_q[$];

  // Scanner mirror: register copies and scan state.
  logic [15:0] cfg_skip;
  logic [21:0] cfg_len;
  logic [9:0]  cfg_max;
  logic [20:0] scan_pos;
  logic [23:0] scan_recent;
  logic [20:0] open_start;
  logic [21:0] open_pay;
  logic [21:0] nz_end;
  logic [4:0]  open_type;
  bit          open_flag;
  logic [9:0]  units_seen;

  bit          in_taken = 1'b0;
  bit          no_gaps  = 1'b0;
  int unsigned fail_cnt = 0;
  int unsigned bytes_sent = 0;
  int unsigned recs_checked = 0;
  int unsigned units_reported = 0;
  int unsigned buffers_closed = 0;
  int unsigned pause_cnt = 0;
  int unsigned phase_cnt = 0;

  function automatic void clear_scan();
    scan_pos    = '0;
    scan_recent = anbs_pkg::RecentRst;
    open_start  = '0;
    open_pay    = '0;
    nz_end      = '0;
    open_type   = '0;
    open_flag   = 1'b0;
    units_seen  = '0;
  endfunction

  // Clamp the programmed length to the address span, and zero up to one byte.
  function automatic int unsigned span_len();
    int unsigned n;
    n = cfg_len;
    if (n > PosSpan) n = PosSpan;
    if (n < 1) n = 1;
    return n;
  endfunction

  function automatic bit code_allowed(int unsigned at, int unsigned n);
    int unsigned lim;
    lim = (cfg_max < UnitCap) ? cfg_max : UnitCap;
    if (at < cfg_skip) return 1'b0;
    if (open_flag && at <= open_pay) return 1'b0;
    if (at + 5 >= n) return 1'b0;
    return units_seen < lim;
  endfunction

  // Record of the open unit, its end trimmed of zeros but never below the payload.
  function automatic nal_rec_t close_unit(logic last);
    nal_rec_t r;
    r.unit_start    = open_start;
    r.payload_start = open_pay;
    r.unit_end      = (nz_end < open_pay) ? open_pay : nz_end;
    r.unit_type     = open_type;
    r.unit_present  = 1'b1;
    r.is_final      = last;
    r.unit_count    = units_seen;
    return r;
  endfunction

  // Advance the mirror by one byte and queue any record it causes.
  task automatic scan_byte(input logic [7:0] b);
    int unsigned p, n, code_at;
    logic [7:0]  b1, b2, b3;
    bit          found;
    nal_rec_t    empty_rec;
    p       = scan_pos;
    n       = span_len();
    b3      = scan_recent[23:16];
    b2      = scan_recent[15:8];
    b1      = scan_recent[7:0];
    found   = 1'b0;
    code_at = 0;
    if (open_flag && p == open_pay) open_type = 5'(b & anbs_pkg::TypeMask);
    if (b == anbs_pkg::StartByte) begin
      // The four-byte form wins where both could begin.
      if (p >= 3 && b3 == 8'h00 && b2 == 8'h00 && b1 == 8'h00 && code_allowed(p - 3, n)) begin
        found   = 1'b1;
        code_at = p - 3;
      end else if (p >= 2 && b2 == 8'h00 && b1 == 8'h00 && code_allowed(p - 2, n)) begin
        found   = 1'b1;
        code_at = p - 2;
      end
    end
    if (found) begin
      if (open_flag) unit_records_due.push_back(close_unit(1'b0));
      open_start = 21'(code_at);
      open_pay   = 22'(p + 1);
      open_type  = '0;
      open_flag  = 1'b1;
      units_seen = units_seen + 10'd1;
    end
    if (b != 8'h00) nz_end = 22'(p + 1);
    scan_recent = {scan_recent[15:0], b};
    if (p + 1 >= n) begin
      if (open_flag) begin
        unit_records_due.push_back(close_unit(1'b1));
      end else begin
        empty_rec          = '0;
        empty_rec.is_final = 1'b1;
        unit_records_due.push_back(empty_rec);
      end
      clear_scan();
    end else begin
      scan_pos = 21'(p + 1);
    end
  endtask

  // Driver: hold an offered byte until taken, otherwise offer the next one or idle.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      byte_bus.valid     <= 1'b0;
      byte_bus.data_byte <= '0;
    end else if (!(byte_bus.valid && !in_taken)) begin
      if (byte_backlog.size() > 0 && (no_gaps || $urandom_range(0, 99) >= 31)) begin
        byte_bus.valid     <= 1'b1;
        byte_bus.data_byte <= byte_backlog[0];
      end else begin
        byte_bus.valid <= 1'b0;
      end
    end
  end

  // Stall the record side at random unless a gap-free stretch is running.
  always @(negedge clk_i) begin
    rec_bus.ready <= no_gaps || ($urandom_range(0, 99) >= 31);
  end

  // Input monitor: every accepted byte drives the mirror.
  always @(posedge clk_i) begin
    in_taken = rst_ni && byte_bus.valid && byte_bus.ready;
    if (in_taken) begin
      void'(byte_backlog.pop_front());
      scan_byte(byte_bus.data_byte);
      bytes_sent++;
    end
  end

  task automatic check_field(input string field, input logic [21:0] want,
                             input logic [21:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
      fail_cnt++;
    end
  endtask

  // Output monitor: compare each record with the oldest one owed.
  always @(posedge clk_i) begin
    nal_rec_t want;
    if (rst_ni && rec_bus.valid && rec_bus.ready) begin
      if (unit_records_due.size() == 0) begin
        $error("record with no unit pending: start 0x%0h count %0d",
               rec_bus.unit_start, rec_bus.unit_count);
        fail_cnt++;
      end else begin
        want = unit_records_due.pop_front();
        check_field("unit_start", 22'(want.unit_start), 22'(rec_bus.unit_start));
        check_field("payload_start", want.payload_start, rec_bus.payload_start);
        check_field("unit_end", want.unit_end, rec_bus.unit_end);
        check_field("unit_type", 22'(want.unit_type), 22'(rec_bus.unit_type));
        check_field("unit_present", 22'(want.unit_present), 22'(rec_bus.unit_present));
        check_field("is_final", 22'(want.is_final), 22'(rec_bus.is_final));
        check_field("unit_count", 22'(want.unit_count), 22'(rec_bus.unit_count));
        recs_checked++;
        if (want.unit_present) units_reported++;
        if (want.is_final) buffers_closed++;
      end
    end
  end

  // Write one register; the mirror picks it up on the same transaction.
  task automatic write_reg(input anbs_pkg::cfg_reg_e idx, input logic [21:0] val);
    @(negedge clk_i);
    cfg_bus.valid = 1'b1;
    cfg_bus.addr  = idx;
    cfg_bus.wdata = val;
    do @(posedge clk_i); while (!cfg_bus.ready);
    case (idx)
      anbs_pkg::REG_HEADER_SKIP:  cfg_skip = val[15:0];
      anbs_pkg::REG_BUFFER_BYTES: cfg_len  = val;
      anbs_pkg::REG_MAX_UNITS:    cfg_max  = val[9:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_bus.valid = 1'b0;
  endtask

  task automatic drain_results();
    while (byte_backlog.size() != 0 || unit_records_due.size() != 0) @(posedge clk_i);
  endtask

  // Drain, then let bytes that cause no record clear the pipeline too.
  task automatic settle();
    drain_results();
    repeat (Settle) @(posedge clk_i);
  endtask

  task automatic program_all(input logic [15:0] skip, input logic [21:0] len,
                             input logic [9:0] maxu);
    settle();
    write_reg(anbs_pkg::REG_HEADER_SKIP, 22'(skip));
    write_reg(anbs_pkg::REG_BUFFER_BYTES, len);
    write_reg(anbs_pkg::REG_MAX_UNITS, 22'(maxu));
  endtask

  // Fill stream_q with count bytes: mostly well-formed units, some broken codes and noise.
  task automatic build_stream(input int unsigned count);
    int unsigned kind;
    logic [7:0]  v;
    stream_q.delete();
    while (stream_q.size() < count) begin
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        repeat ($urandom_range(0, 1)) stream_q.push_back(8'h00);
        stream_q.push_back(8'h00);
        stream_q.push_back(8'h00);
        if ($urandom_range(0, 1)) stream_q.push_back(8'h00);
        stream_q.push_back(anbs_pkg::StartByte);
        stream_q.push_back(8'($urandom_range(0, 255)));
        repeat ($urandom_range(0, 10)) begin
          v = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
          stream_q.push_back(v);
        end
        repeat ($urandom_range(0, 3)) stream_q.push_back(8'h00);
      end else if (kind == 7) begin
        // Near misses: 00 01, or 00 00 followed by something other than 01.
        stream_q.push_back(8'h00);
        if ($urandom_range(0, 1)) begin
          stream_q.push_back(anbs_pkg::StartByte);
        end else begin
          stream_q.push_back(8'h00);
          stream_q.push_back(8'($urandom_range(2, 255)));
        end
      end else begin
        repeat ($urandom_range(1, 6)) stream_q.push_back(8'($urandom_range(0, 255)));
      end
    end
    while (stream_q.size() > count) void'(stream_q.pop_back());
  endtask

  // Queue one buffer; sometimes hold the sender mid-buffer until all records are in.
  task automatic feed_buffer(input int unsigned len);
    int unsigned cut;
    build_stream(len);
    cut = len;
    if (len > 12 && (pause_cnt == 0 || $urandom_range(0, 3) == 0)) begin
      cut = $urandom_range(4, len - 4);
      pause_cnt++;
    end
    for (int unsigned i = 0; i < len; i++) begin
      if (i == cut) drain_results();
      byte_backlog.push_back(stream_q[i]);
    end
  endtask

  task automatic push_list(input logic [7:0] b0, input logic [7:0] b1, input logic [7:0] b2,
                           input logic [7:0] b3, input logic [7:0] b4, input logic [7:0] b5);
    byte_backlog.push_back(b0);
    byte_backlog.push_back(b1);
    byte_backlog.push_back(b2);
    byte_backlog.push_back(b3);
    byte_backlog.push_back(b4);
    byte_backlog.push_back(b5);
  endtask

  initial begin
    logic [15:0] skip;
    logic [21:0] len;
    logic [9:0]  maxu;
    int unsigned rand_sent, wait_cnt;

    // Drive the config inputs to a known value, then hold reset.
    rst_ni        = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.addr  = anbs_pkg::REG_HEADER_SKIP;
    cfg_bus.wdata = '0;
    cfg_skip      = anbs_pkg::HeaderSkipRst;
    cfg_len       = anbs_pkg::BufferBytesRst;
    cfg_max       = anbs_pkg::MaxUnitsRst;
    clear_scan();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: shortest buffers with a four-byte code, a three-byte code with a
    // zero-type header and trimmed tail, a code too close to the end, and a
    // header skip that forces the three-byte form inside a four-byte run.
    program_all(16'd0, 22'd6, 10'd512);
    push_list(8'h00, 8'h00, 8'h00, 8'h01, 8'h65, 8'hFF);
    push_list(8'h00, 8'h00, 8'h01, 8'hE0, 8'h00, 8'h00);
    push_list(8'hFF, 8'h00, 8'h00, 8'h01, 8'h80, 8'h00);
    program_all(16'd1, 22'd7, 10'd1);
    push_list(8'h00, 8'h00, 8'h00, 8'h01, 8'h2A, 8'h7F);
    byte_backlog.push_back(8'h00);

    // Oversized length, then the exact address span, then shrink it under the
    // current position so the next byte closes the buffer.
    program_all(16'd0, 22'h3FFFFF, 10'd512);
    feed_buffer(40);
    settle();
    write_reg(anbs_pkg::REG_BUFFER_BYTES, 22'(PosSpan));
    feed_buffer(20);
    settle();
    write_reg(anbs_pkg::REG_BUFFER_BYTES, 22'd10);
    byte_backlog.push_back(8'($urandom_range(0, 255)));

    // Random phases; the first few pin one register at an extreme.
    rand_sent = 0;
    while (rand_sent < RandBytes) begin
      skip = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 40)) : 16'($urandom_range(0, 6));
      len  = 22'($urandom_range(6, 64));
      maxu = 10'($urandom_range(1, 6));
      case (phase_cnt)
        0: maxu = 10'd0;
        1: maxu = 10'h3FF;
        2: skip = 16'hFFFF;
        3: len  = 22'd0;
        4: len  = 22'd5;
        5: len  = 22'd1;
        6: maxu = 10'd512;
        default: ;
      endcase
      program_all(skip, len, maxu);
      no_gaps = (phase_cnt == 8 || phase_cnt == 9);
      repeat ($urandom_range(1, 3)) begin
        feed_buffer((len == 0) ? 1 : len);
        rand_sent += (len == 0) ? 1 : len;
      end
      phase_cnt++;
    end
    no_gaps = 1'b0;

    // Wait for the last records, bounded, then give the pipeline a few more cycles.
    wait_cnt = 0;
    while ((byte_backlog.size() != 0 || unit_records_due.size() != 0) && wait_cnt < 20000) begin
      @(posedge clk_i);
      wait_cnt++;
    end
    repeat (Settle) @(posedge clk_i);
    if (unit_records_due.size() != 0) begin
      $error("%0d unit records never arrived", unit_records_due.size());
      fail_cnt++;
    end

    $display("Scanned %0d bytes over %0d random phases, %0d mid-buffer holds.",
             bytes_sent, phase_cnt, pause_cnt);
    $display("Checked %0d records: %0d units, %0d buffers closed.",
             recs_checked, units_reported, buffers_closed);
    if (fail_cnt == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
